>>> hdl/tfmc_pkg.sv
// shared types, constants and helpers of the three-frame motion counter
`default_nettype none

package tfmc_pkg;

  localparam int unsigned LanesDefault          = 8;
  localparam int unsigned MaxFramePixelsDefault = 131072;

  localparam int unsigned PixW      = 8;
  localparam int unsigned FieldW    = 64;
  localparam int unsigned LaneCntW  = 4;
  localparam int unsigned InDataW   = 264;
  localparam int unsigned OutCountW = 18;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned ThrW      = 8;
  localparam int unsigned RatioW    = 17;
  localparam int unsigned Q16Frac   = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW     = 2;

  localparam logic [RatioW-1:0] Q16One     = 17'h10000;
  localparam logic [ThrW-1:0]   ThrReset   = 8'd0;
  localparam logic [RatioW-1:0] RatioReset = 17'd655;

  typedef enum logic [CfgIdxW-1:0] {
    RegDiffThreshold = 1'b0,
    RegTriggerRatio  = 1'b1
  } cfg_reg_e;

  // classified item passed from front to back
  typedef struct packed {
    logic [LaneCntW-1:0] hits;
    logic [LaneCntW-1:0] lanes;
    logic                last;
  } tfmc_cls_t;

  function automatic logic [PixW-1:0] abs_diff(input logic [PixW-1:0] a,
                                               input logic [PixW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> hdl/tfmc_front.sv
// front end: accepts pixel items and reduces each to a hit count and lane count
`default_nettype none

module tfmc_front import tfmc_pkg::*; #(
  parameter int unsigned LANES = LanesDefault
) (
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [FieldW-1:0]   oldest_i,
  input  logic [FieldW-1:0]   middle_i,
  input  logic [FieldW-1:0]   newest_i,
  input  logic [FieldW-1:0]   roi_i,
  input  logic [LaneCntW-1:0] valid_lanes_i,
  input  logic                last_i,
  input  logic [ThrW-1:0]     thr_i,
  input  logic                q_full_i,
  output logic                push_o,
  output tfmc_cls_t           cls_o
);

  localparam logic [LaneCntW-1:0] LanesC = LaneCntW'(LANES);

  logic [LaneCntW-1:0] lanes_eff;
  logic [LANES-1:0]    hit_vec;
  logic [LaneCntW-1:0] hits;

  assign lanes_eff = (valid_lanes_i > LanesC) ? LanesC : valid_lanes_i;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [PixW-1:0] a, b, c, m, d10, d21, dmin;
    assign a    = oldest_i[i*PixW +: PixW];
    assign b    = middle_i[i*PixW +: PixW];
    assign c    = newest_i[i*PixW +: PixW];
    assign m    = roi_i[i*PixW +: PixW];
    assign d10  = abs_diff(b, a);
    assign d21  = abs_diff(c, b);
    assign dmin = (d10 < d21) ? d10 : d21;
    assign hit_vec[i] = (LaneCntW'(i) < lanes_eff) && (m != '0) && (dmin > thr_i);
  end

  always_comb begin
    hits = '0;
    for (int i = 0; i < LANES; i++) begin
      hits = hits + LaneCntW'(hit_vec[i]);
    end
  end

  assign s_ready_o   = !q_full_i;
  assign push_o      = s_valid_i && !q_full_i;
  assign cls_o.hits  = hits;
  assign cls_o.lanes = lanes_eff;
  assign cls_o.last  = last_i;

endmodule

`default_nettype wire

>>> hdl/tfmc_queue.sv
// small fifo of classified items between front and back
`default_nettype none

module tfmc_queue import tfmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tfmc_cls_t data_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output tfmc_cls_t data_o
);

  tfmc_cls_t        mem [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tfmc_back.sv
// back end: frame accumulation, ratio test and output register
`default_nettype none

module tfmc_back import tfmc_pkg::*; #(
  parameter int unsigned MAX_FRAME_PIXELS = MaxFramePixelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tfmc_cls_t           q_data_i,
  output logic                q_pop_o,
  input  logic [RatioW-1:0]   ratio_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [OutDataW-1:0] m_data_o
);

  localparam int unsigned CntW  = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned ProdW = CntW + RatioW;
  localparam int unsigned PadW  = OutDataW - 2*OutCountW - 1;
  localparam logic [CntW-1:0] MaxC = CntW'(MAX_FRAME_PIXELS);

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0]     acc,
                                              input logic [LaneCntW-1:0] inc);
    logic [CntW:0] sum;
    sum = {1'b0, acc} + (CntW+1)'(inc);
    return (sum > {1'b0, MaxC}) ? MaxC : sum[CntW-1:0];
  endfunction

  logic [CntW-1:0] chg_q, chg_d, pix_q, pix_d, chg_sum, pix_sum;
  logic            fin_valid_q;
  logic [CntW-1:0] fin_chg_q, fin_pix_q;
  logic            mul_valid_q;
  logic [CntW-1:0] mul_chg_q, mul_pix_q;
  logic [ProdW-1:0] prod_q, prod_d;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [RatioW-1:0] ratio_sat;
  logic [ProdW-1:0] lhs;
  logic            motion;
  logic            out_rdy, mul_rdy, fin_rdy, pop, fin_load;

  // ready chain through the result stages
  assign out_rdy  = !out_valid_q || m_ready_i;
  assign mul_rdy  = !mul_valid_q || out_rdy;
  assign fin_rdy  = !fin_valid_q || mul_rdy;
  // running items never wait; only a frame end needs a free result slot
  assign pop      = q_valid_i && (!q_data_i.last || fin_rdy);
  assign fin_load = pop && q_data_i.last;
  assign q_pop_o  = pop;

  assign chg_sum = sat_add(chg_q, q_data_i.hits);
  assign pix_sum = sat_add(pix_q, q_data_i.lanes);

  always_comb begin
    chg_d = chg_q;
    pix_d = pix_q;
    if (pop) begin
      chg_d = q_data_i.last ? '0 : chg_sum;
      pix_d = q_data_i.last ? '0 : pix_sum;
    end
  end

  assign ratio_sat = (ratio_i > Q16One) ? Q16One : ratio_i;
  assign prod_d    = ProdW'(ratio_sat) * ProdW'(fin_pix_q);
  assign lhs       = ProdW'({mul_chg_q, {Q16Frac{1'b0}}});
  assign motion    = (lhs >= prod_q);
  assign out_data_d = {{PadW{1'b0}}, motion, OutCountW'(mul_pix_q), OutCountW'(mul_chg_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_q       <= '0;
      pix_q       <= '0;
      fin_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      chg_q <= chg_d;
      pix_q <= pix_d;
      if (fin_rdy) begin
        fin_valid_q <= fin_load;
      end
      if (mul_rdy) begin
        mul_valid_q <= fin_valid_q;
      end
      if (out_rdy) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_rdy && fin_load) begin
      fin_chg_q <= chg_sum;
      fin_pix_q <= pix_sum;
    end
    if (mul_rdy && fin_valid_q) begin
      mul_chg_q <= fin_chg_q;
      mul_pix_q <= fin_pix_q;
      prod_q    <= prod_d;
    end
    if (out_rdy && mul_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> hdl/three_frame_motion_counter.sv
// top level of the three-frame difference motion counter
`default_nettype none

// Takes one item of up to LANES co-located pixels from three frames every clock
// and counts pixels whose ROI byte is nonzero and whose smaller frame difference
// exceeds diff_threshold. The front classifies each item in the cycle it is
// accepted and writes it into a four-entry queue; the back pops one queued item
// per clock into the saturating frame counters. The item marked with tlast
// yields one result (changed count, frame pixels, motion flag) after it leaves
// the queue, through a count stage, a multiply stage for the ratio test and
// the output register. Items without tlast produce nothing.
// Sustained rate is one item per clock as long as m_axis_tready keeps up with
// the frame results; s_axis_tready drops only when the queue is full.
module three_frame_motion_counter import tfmc_pkg::*; #(
  parameter int unsigned LANES            = LanesDefault,
  parameter int unsigned MAX_FRAME_PIXELS = MaxFramePixelsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // oldest_pixels, middle_pixels, newest_pixels, roi_bytes, valid_lanes, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // changed_count, frame_pixels, motion_detected, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [ThrW-1:0]   thr_q, thr_d;
  logic [RatioW-1:0] ratio_q, ratio_d;
  logic              push, q_full, q_valid, q_pop;
  tfmc_cls_t         cls_in, cls_out;

  always_comb begin
    thr_d   = thr_q;
    ratio_d = ratio_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegDiffThreshold: thr_d   = cfg_data_i[ThrW-1:0];
        RegTriggerRatio:  ratio_d = cfg_data_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThrReset;
      ratio_q <= RatioReset;
    end else begin
      thr_q   <= thr_d;
      ratio_q <= ratio_d;
    end
  end

  tfmc_front #(
    .LANES(LANES)
  ) u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .oldest_i     (s_axis_tdata[FieldW-1:0]),
    .middle_i     (s_axis_tdata[2*FieldW-1:FieldW]),
    .newest_i     (s_axis_tdata[3*FieldW-1:2*FieldW]),
    .roi_i        (s_axis_tdata[4*FieldW-1:3*FieldW]),
    .valid_lanes_i(s_axis_tdata[4*FieldW +: LaneCntW]),
    .last_i       (s_axis_tlast),
    .thr_i        (thr_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .cls_o        (cls_in)
  );

  tfmc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (cls_out)
  );

  tfmc_back #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (cls_out),
    .q_pop_o  (q_pop),
    .ratio_i  (ratio_q),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire
